// ===== rtl/lagged_history_hermite_lookup_macros.svh =====
// Assertion macros for the lagged history Hermite lookup.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef LAGGED_HISTORY_HERMITE_LOOKUP_MACROS_SVH
`define LAGGED_HISTORY_HERMITE_LOOKUP_MACROS_SVH

// same-cycle implication
`define LHHL_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lhhl check failed");

// next-cycle implication
`define LHHL_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lhhl check failed");

`endif

// ===== rtl/lhhl_pkg.sv =====
// Shared types, constants and fixed-point helpers for the lagged history lookup.
// No dependencies; the module files refer to it by scoped names.
package lhhl_pkg;

    localparam int DEPTH       = 1024;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int NUM_VARS    = 4;
    localparam int VAR_W       = 2;
    localparam int NUM_MARKERS = 4;
    localparam int MK_W        = 2;
    localparam int MADDR_W     = VAR_W + SLOT_W;
    localparam int MKIDX_W     = VAR_W + MK_W;
    localparam int TIME_W      = 48;
    localparam int VAL_W       = 32;

    typedef logic signed [63:0] wide_t;

    localparam wide_t W_MAX = {1'b0, {63{1'b1}}};
    localparam wide_t W_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [1:0] {
        REQ_ADVANCE = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_VALUE   = 2'd2,
        REQ_SLOPE   = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_NEW_RD, ST_NEW_CMP, ST_FWD_RD, ST_FWD_CMP,
        ST_BWD_RD, ST_BWD_CMP, ST_LD_X1, ST_LD_Y0, ST_LD_Y1, ST_DECIDE,
        ST_SW_GO, ST_SW_WT, ST_DIV_GO, ST_DIV_WT, ST_C1_GO, ST_C1_WT,
        ST_C1B_GO, ST_C1B_WT, ST_C23, ST_P1_GO, ST_P1_WT, ST_P2_GO,
        ST_P2_WT, ST_P3_GO, ST_P3_WT, ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_ACCEPT, OP_RD_NEW, OP_NEW_CMP, OP_FWD_RD,
        OP_FWD_CMP, OP_BWD_RD, OP_BWD_CMP, OP_LD_X1, OP_LD_Y0, OP_LD_Y1,
        OP_DECIDE, OP_SWITCH, OP_POS, OP_C1, OP_C1B, OP_C23, OP_P1, OP_P2,
        OP_P3
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   go;
        logic   load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic exact;
        logic fwd_more;
        logic bwd_more;
        logic late;
        logic sw_case;
        logic zero_int;
        logic grad;
        logic done;
    } status_t;

    function automatic logic [63:0] mag64(input wide_t x);
        mag64 = x[63] ? (~x + 64'd1) : x;
    endfunction

    // sign and 128-bit magnitude to a saturated signed 64-bit value
    function automatic wide_t settle(input logic neg, input logic [63:0] hi,
                                     input logic [63:0] lo);
        if (!neg)
            settle = (hi != 64'd0 || lo[63]) ? W_MAX : wide_t'(lo);
        else if (hi != 64'd0 || lo[63])
            settle = W_MIN;
        else
            settle = wide_t'(~lo + 64'd1);
    endfunction

    function automatic wide_t sadd(input wide_t a, input wide_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            sadd = s[64] ? W_MIN : W_MAX;
        else
            sadd = s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t x);
        if (x > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = x[31:0];
    endfunction

endpackage

// ===== rtl/lagged_history_hermite_lookup.sv =====
// Channel  | beat fields (tdata, tuser)                                | direction
// s_axis   | time_point, sample_value, sample_slope; req, var, marker | in
// m_axis   | result_value; lag_too_large                              | out
//
// After reset the stamp ring is cleared, one slot a cycle, with tready low.
// Advance and write beats go straight to the finish state; a query walks the ring slot
// by slot and may then run multiply steps and bit-serial divides (one divide for a value,
// two for a gradient).
// A finished result waits in the output register while the next beat is taken.
// Top level: lhhl_ctrl and lhhl_dpath; needs lhhl_pkg and the macros header.
`include "lagged_history_hermite_lookup_macros.svh"

module lagged_history_hermite_lookup (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,  // time_point[47:0], sample_value, sample_slope
    input  logic [5:0]    s_axis_tuser,  // req_type[1:0], var_index, marker_index
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata,  // result_value[31:0]
    output logic          m_axis_tuser   // lag_too_large
);

    lhhl_pkg::cmd_t    cmd;
    lhhl_pkg::status_t status;
    logic signed [lhhl_pkg::VAL_W-1:0] result_value;

    lhhl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lhhl_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (lhhl_pkg::req_t'(s_axis_tuser[1:0])),
        .var_index     (s_axis_tuser[3:2]),
        .marker_index  (s_axis_tuser[5:4]),
        .time_point    (s_axis_tdata[47:0]),
        .sample_value  (s_axis_tdata[79:48]),
        .sample_slope  (s_axis_tdata[111:80]),
        .status        (status),
        .result_value  (result_value),
        .lag_too_large (m_axis_tuser)
    );

    assign m_axis_tdata = result_value;

    `LHHL_IMPLIES(a_lag_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)
    `LHHL_NEXT(a_single_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `LHHL_NEXT(a_load_shows, cmd.load_out, m_axis_tvalid)

endmodule

// ===== rtl/lhhl_mul.sv =====
// Signed 64x64 multiply with right shift by 24 or 32, saturated to 64 bits.
// Four 32x32 partial products over successive cycles; uses lhhl_pkg helpers.
module lhhl_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lhhl_pkg::wide_t a,
    input  lhhl_pkg::wide_t b,
    input  logic            sh32,
    output logic            done,
    output lhhl_pkg::wide_t result
);

    logic [63:0]     ma_reg, mb_reg;
    logic            neg_reg, sh32_reg;
    logic [127:0]    acc_reg;
    logic [63:0]     pp_reg;
    logic [1:0]      ppsh_reg;
    logic            ppv_reg;
    logic [2:0]      cnt_reg;
    logic            busy_reg, done_reg;
    lhhl_pkg::wide_t res_reg;

    logic [31:0]  sel_a, sel_b;
    logic [127:0] pp_add, shifted;

    always_comb
    begin
        sel_a = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        sel_b = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        case (ppsh_reg)
            2'd0:    pp_add = {64'd0, pp_reg};
            2'd1:    pp_add = {32'd0, pp_reg, 32'd0};
            default: pp_add = {pp_reg, 64'd0};
        endcase
        shifted = sh32_reg ? (acc_reg >> 32) : (acc_reg >> 24);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            ppv_reg <= (cnt_reg < 3'd4);
            if (cnt_reg == 3'd5)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg   <= lhhl_pkg::mag64(a);
            mb_reg   <= lhhl_pkg::mag64(b);
            neg_reg  <= a[63] ^ b[63];
            sh32_reg <= sh32;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                pp_reg   <= sel_a * sel_b;
                ppsh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (ppv_reg)
                acc_reg <= acc_reg + pp_add;
            if (cnt_reg == 3'd5)
                res_reg <= lhhl_pkg::settle(neg_reg, shifted[127:64], shifted[63:0]);
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/lhhl_div.sv =====
// Signed (a << 24 or 32) / d, toward zero, saturated to 64 bits.
// Restoring divider, one quotient bit per cycle; uses lhhl_pkg.
module lhhl_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lhhl_pkg::wide_t a,
    input  lhhl_pkg::wide_t d,
    input  logic            sh32,
    output logic            done,
    output lhhl_pkg::wide_t result
);

    logic [127:0]    dq_reg;
    logic [63:0]     rem_reg, dm_reg;
    logic            neg_reg;
    logic [7:0]      cnt_reg;
    logic            busy_reg, done_reg;
    lhhl_pkg::wide_t res_reg;

    logic [64:0] r2, diff;
    logic [63:0] ma;
    logic        take;

    always_comb
    begin
        ma   = lhhl_pkg::mag64(a);
        r2   = {rem_reg, dq_reg[127]};
        diff = r2 - {1'b0, dm_reg};
        take = !diff[64];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg[7])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
                cnt_reg <= cnt_reg + 8'd1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dm_reg  <= lhhl_pkg::mag64(d);
            neg_reg <= a[63] ^ d[63];
            rem_reg <= '0;
            dq_reg  <= sh32 ? {32'd0, ma, 32'd0} : {40'd0, ma, 24'd0};
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[7])
            begin
                rem_reg <= take ? diff[63:0] : r2[63:0];
                dq_reg  <= {dq_reg[126:0], take};
            end
            else
                res_reg <= lhhl_pkg::settle(neg_reg, dq_reg[127:64], dq_reg[63:0]);
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/lhhl_dpath.sv =====
// Datapath: stamp, value and slope memories, place markers, search and
// Hermite arithmetic registers. Driven by lhhl_ctrl; uses lhhl_mul, lhhl_div, lhhl_pkg.
module lhhl_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lhhl_pkg::cmd_t                      cmd,
    input  lhhl_pkg::req_t                      req_type,
    input  logic [lhhl_pkg::VAR_W-1:0]          var_index,
    input  logic [lhhl_pkg::MK_W-1:0]           marker_index,
    input  logic signed [lhhl_pkg::TIME_W-1:0]  time_point,
    input  logic signed [lhhl_pkg::VAL_W-1:0]   sample_value,
    input  logic signed [lhhl_pkg::VAL_W-1:0]   sample_slope,
    output lhhl_pkg::status_t                   status,
    output logic signed [lhhl_pkg::VAL_W-1:0]   result_value,
    output logic                                lag_too_large
);

    localparam int SW = lhhl_pkg::SLOT_W;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] x);
        slot_inc = (x == SW'(lhhl_pkg::DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] x);
        slot_dec = (x == '0) ? SW'(lhhl_pkg::DEPTH - 1) : x - 1'b1;
    endfunction

    // memories
    logic signed [lhhl_pkg::TIME_W-1:0] stamp_mem [lhhl_pkg::DEPTH];
    logic signed [lhhl_pkg::VAL_W-1:0]  val_mem [lhhl_pkg::NUM_VARS * lhhl_pkg::DEPTH];
    logic signed [lhhl_pkg::VAL_W-1:0]  slp_mem [lhhl_pkg::NUM_VARS * lhhl_pkg::DEPTH];
    logic signed [lhhl_pkg::TIME_W-1:0] stamp_q;
    logic signed [lhhl_pkg::VAL_W-1:0]  val_q, slp_q;

    // control registers
    logic [SW-1:0] newest_reg, clr_reg;
    logic [SW-1:0] markers_reg [lhhl_pkg::NUM_VARS * lhhl_pkg::NUM_MARKERS];

    // payload registers
    lhhl_pkg::req_t                     req_reg;
    logic [lhhl_pkg::VAR_W-1:0]         var_reg;
    logic [lhhl_pkg::MK_W-1:0]          mk_reg;
    logic signed [lhhl_pkg::TIME_W-1:0] t_reg, x0_reg, x1_reg;
    logic signed [lhhl_pkg::VAL_W-1:0]  y0_reg, y1_reg, g0_reg, g1_reg;
    logic [SW-1:0]                      k_reg, k1_reg;
    lhhl_pkg::wide_t                    h_reg, s_reg, c1_reg, c1b_reg, c2_reg, c3_reg;
    lhhl_pkg::wide_t                    a_reg, res_reg;
    logic                               late_reg;
    logic signed [lhhl_pkg::VAL_W-1:0]  out_data_reg;
    logic                               out_late_reg;

    logic [SW-1:0]                   offp, stamp_ra, stamp_wa;
    logic [lhhl_pkg::MADDR_W-1:0]    val_ra, val_wa;
    logic [lhhl_pkg::MKIDX_W-1:0]    mk_idx;
    logic                            stamp_we, val_we, grad, in_var_ok;
    logic signed [lhhl_pkg::TIME_W-1:0] stamp_wd;
    lhhl_pkg::wide_t t_w, x0_w, x1_w, y0_w, y1_w, g0_w, g1_w, d_w, c3x3;
    lhhl_pkg::wide_t mul_a, mul_b, div_a, div_d, mres, dres;
    logic            mul_sh32, mul_start, div_sh32, div_start, mul_done, div_done;

    always_comb
    begin
        offp   = slot_inc(newest_reg);
        mk_idx = {var_reg, mk_reg};
        grad   = (req_reg == lhhl_pkg::REQ_SLOPE);
        in_var_ok = int'(var_index) < lhhl_pkg::NUM_VARS;

        t_w  = {{16{t_reg[47]}}, t_reg};
        x0_w = {{16{x0_reg[47]}}, x0_reg};
        x1_w = {{16{x1_reg[47]}}, x1_reg};
        y0_w = {{32{y0_reg[31]}}, y0_reg};
        y1_w = {{32{y1_reg[31]}}, y1_reg};
        g0_w = {{32{g0_reg[31]}}, g0_reg};
        g1_w = {{32{g1_reg[31]}}, g1_reg};
        d_w  = y1_w - y0_w;
        c3x3 = c3_reg + (c3_reg <<< 1);

        stamp_we = 1'b0;
        stamp_wa = clr_reg;
        stamp_wd = '0;
        if (cmd.op == lhhl_pkg::OP_CLEAR)
            stamp_we = 1'b1;
        else if (cmd.op == lhhl_pkg::OP_ACCEPT && req_type == lhhl_pkg::REQ_ADVANCE)
        begin
            stamp_we = 1'b1;
            stamp_wa = offp;
            stamp_wd = time_point;
        end

        val_we = (cmd.op == lhhl_pkg::OP_ACCEPT) && (req_type == lhhl_pkg::REQ_WRITE)
                 && in_var_ok;
        val_wa = {var_index, newest_reg};

        unique case (cmd.op)
            lhhl_pkg::OP_RD_NEW:
            begin
                stamp_ra = newest_reg;
                val_ra   = {var_reg, newest_reg};
            end
            lhhl_pkg::OP_FWD_RD:
            begin
                stamp_ra = k1_reg;
                val_ra   = {var_reg, k_reg};
            end
            lhhl_pkg::OP_LD_X1:
            begin
                stamp_ra = k1_reg;
                val_ra   = {var_reg, k_reg};
            end
            lhhl_pkg::OP_LD_Y0:
            begin
                stamp_ra = k_reg;
                val_ra   = {var_reg, k1_reg};
            end
            default:
            begin
                stamp_ra = k_reg;
                val_ra   = {var_reg, k_reg};
            end
        endcase

        // shared arithmetic unit operands
        mul_a     = s_reg;
        mul_b     = a_reg;
        mul_sh32  = 1'b1;
        div_a     = a_reg;
        div_d     = h_reg;
        div_sh32  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        unique case (cmd.op)
            lhhl_pkg::OP_SWITCH:
            begin
                mul_a     = t_w - x1_w;
                mul_b     = g1_w;
                mul_sh32  = 1'b0;
                mul_start = cmd.go;
            end
            lhhl_pkg::OP_C1:
            begin
                mul_a     = g0_w;
                mul_b     = h_reg;
                mul_sh32  = 1'b0;
                mul_start = cmd.go;
            end
            lhhl_pkg::OP_C1B:
            begin
                mul_a     = g1_w;
                mul_b     = h_reg;
                mul_sh32  = 1'b0;
                mul_start = cmd.go;
            end
            lhhl_pkg::OP_P1:
            begin
                mul_b     = grad ? c3x3 : c3_reg;
                mul_start = cmd.go;
            end
            lhhl_pkg::OP_P2:
                mul_start = cmd.go;
            lhhl_pkg::OP_P3:
            begin
                mul_start = cmd.go && !grad;
                div_start = cmd.go && grad;
            end
            lhhl_pkg::OP_POS:
            begin
                div_a     = t_w - x0_w;
                div_sh32  = 1'b1;
                div_start = cmd.go;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase

        status.clr_last = (clr_reg == SW'(lhhl_pkg::DEPTH - 1));
        status.is_query = (req_type == lhhl_pkg::REQ_VALUE || req_type == lhhl_pkg::REQ_SLOPE)
                          && in_var_ok && (int'(marker_index) < lhhl_pkg::NUM_MARKERS);
        status.exact    = (req_reg == lhhl_pkg::REQ_VALUE) && (stamp_q == t_reg);
        status.fwd_more = (stamp_q < t_reg) && (k1_reg != newest_reg);
        status.bwd_more = (stamp_q > t_reg) && (k_reg != offp);
        status.late     = (t_reg < stamp_q);
        status.sw_case  = (t_reg > x1_reg) && (x0_reg == x1_reg);
        status.zero_int = (x0_reg == x1_reg);
        status.grad     = grad;
        status.done     = mul_done | div_done;
    end

    lhhl_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .sh32   (mul_sh32),
        .done   (mul_done),
        .result (mres)
    );

    lhhl_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .a      (div_a),
        .d      (div_d),
        .sh32   (div_sh32),
        .done   (div_done),
        .result (dres)
    );

    always_ff @(posedge clk)
    begin
        if (stamp_we)
            stamp_mem[stamp_wa] <= stamp_wd;
        stamp_q <= stamp_mem[stamp_ra];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_wa] <= sample_value;
            slp_mem[val_wa] <= sample_slope;
        end
        val_q <= val_mem[val_ra];
        slp_q <= slp_mem[val_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= SW'(lhhl_pkg::DEPTH - 1);
            clr_reg    <= '0;
            for (int i = 0; i < lhhl_pkg::NUM_VARS * lhhl_pkg::NUM_MARKERS; i++)
                markers_reg[i] <= '0;
        end
        else
        begin
            if (cmd.op == lhhl_pkg::OP_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.op == lhhl_pkg::OP_ACCEPT && req_type == lhhl_pkg::REQ_ADVANCE)
                newest_reg <= offp;
            // every lookup that reaches the decision moves the marker
            if (cmd.op == lhhl_pkg::OP_DECIDE)
                markers_reg[mk_idx] <= k_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            lhhl_pkg::OP_ACCEPT:
            begin
                req_reg  <= req_type;
                var_reg  <= var_index;
                mk_reg   <= marker_index;
                t_reg    <= time_point;
                res_reg  <= '0;
                late_reg <= 1'b0;
            end
            lhhl_pkg::OP_NEW_CMP:
            begin
                if (status.exact)
                    res_reg <= {{32{val_q[31]}}, val_q};
                else
                    k1_reg <= slot_inc(markers_reg[mk_idx]);
            end
            lhhl_pkg::OP_FWD_CMP:
            begin
                if (status.fwd_more)
                    k1_reg <= slot_inc(k1_reg);
                else
                    k_reg <= slot_dec(k1_reg);
            end
            lhhl_pkg::OP_BWD_CMP:
            begin
                if (status.bwd_more)
                    k_reg <= slot_dec(k_reg);
                else
                begin
                    k1_reg   <= slot_inc(k_reg);
                    late_reg <= status.late;
                    x0_reg   <= stamp_q;
                end
            end
            lhhl_pkg::OP_LD_Y0:
            begin
                x1_reg <= stamp_q;
                y0_reg <= val_q;
                g0_reg <= slp_q;
            end
            lhhl_pkg::OP_LD_Y1:
            begin
                y1_reg <= val_q;
                g1_reg <= slp_q;
            end
            lhhl_pkg::OP_DECIDE:
            begin
                h_reg <= x1_w - x0_w;
                if (status.sw_case)
                    res_reg <= g1_w;
                else if (status.zero_int)
                    res_reg <= grad ? g0_w : y0_w;
            end
            lhhl_pkg::OP_SWITCH:
                if (mul_done)
                    res_reg <= lhhl_pkg::sadd(y1_w, mres);
            lhhl_pkg::OP_POS:
                if (div_done)
                    s_reg <= dres;
            lhhl_pkg::OP_C1:
                if (mul_done)
                    c1_reg <= mres;
            lhhl_pkg::OP_C1B:
                if (mul_done)
                    c1b_reg <= mres;
            lhhl_pkg::OP_C23:
            begin
                c2_reg <= d_w + (d_w <<< 1) - (c1_reg <<< 1) - c1b_reg;
                c3_reg <= c1_reg + c1b_reg - (d_w <<< 1);
            end
            lhhl_pkg::OP_P1:
                if (mul_done)
                    a_reg <= lhhl_pkg::sadd(grad ? (c2_reg <<< 1) : c2_reg, mres);
            lhhl_pkg::OP_P2:
                if (mul_done)
                    a_reg <= lhhl_pkg::sadd(c1_reg, mres);
            lhhl_pkg::OP_P3:
            begin
                if (div_done)
                    res_reg <= dres;
                else if (mul_done)
                    res_reg <= lhhl_pkg::sadd(y0_w, mres);
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
        if (cmd.load_out)
        begin
            out_data_reg <= lhhl_pkg::sat32(res_reg);
            out_late_reg <= late_reg;
        end
    end

    assign result_value  = out_data_reg;
    assign lag_too_large = out_late_reg;

endmodule

// ===== rtl/lhhl_ctrl.sv =====
// Controller: sequences clearing pass, ring search, loads and arithmetic steps.
// Issues lhhl_pkg::cmd_t to lhhl_dpath and reads its status; owns the result valid.
module lhhl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  lhhl_pkg::status_t   status,
    output lhhl_pkg::cmd_t      cmd
);

    lhhl_pkg::state_t state_reg, state_next;
    logic             out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lhhl_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = lhhl_pkg::OP_NONE;
        cmd.go       = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            lhhl_pkg::ST_CLEAR:
            begin
                cmd.op = lhhl_pkg::OP_CLEAR;
                if (status.clr_last)
                    state_next = lhhl_pkg::ST_IDLE;
            end
            lhhl_pkg::ST_IDLE:
                if (in_valid)
                begin
                    cmd.op     = lhhl_pkg::OP_ACCEPT;
                    state_next = status.is_query ? lhhl_pkg::ST_NEW_RD : lhhl_pkg::ST_FINISH;
                end
            lhhl_pkg::ST_NEW_RD:
            begin
                cmd.op     = lhhl_pkg::OP_RD_NEW;
                state_next = lhhl_pkg::ST_NEW_CMP;
            end
            lhhl_pkg::ST_NEW_CMP:
            begin
                cmd.op     = lhhl_pkg::OP_NEW_CMP;
                state_next = status.exact ? lhhl_pkg::ST_FINISH : lhhl_pkg::ST_FWD_RD;
            end
            lhhl_pkg::ST_FWD_RD:
            begin
                cmd.op     = lhhl_pkg::OP_FWD_RD;
                state_next = lhhl_pkg::ST_FWD_CMP;
            end
            lhhl_pkg::ST_FWD_CMP:
            begin
                cmd.op     = lhhl_pkg::OP_FWD_CMP;
                state_next = status.fwd_more ? lhhl_pkg::ST_FWD_RD : lhhl_pkg::ST_BWD_RD;
            end
            lhhl_pkg::ST_BWD_RD:
            begin
                cmd.op     = lhhl_pkg::OP_BWD_RD;
                state_next = lhhl_pkg::ST_BWD_CMP;
            end
            lhhl_pkg::ST_BWD_CMP:
            begin
                cmd.op = lhhl_pkg::OP_BWD_CMP;
                if (status.bwd_more)
                    state_next = lhhl_pkg::ST_BWD_RD;
                else if (status.late)
                    state_next = lhhl_pkg::ST_FINISH;
                else
                    state_next = lhhl_pkg::ST_LD_X1;
            end
            lhhl_pkg::ST_LD_X1:
            begin
                cmd.op     = lhhl_pkg::OP_LD_X1;
                state_next = lhhl_pkg::ST_LD_Y0;
            end
            lhhl_pkg::ST_LD_Y0:
            begin
                cmd.op     = lhhl_pkg::OP_LD_Y0;
                state_next = lhhl_pkg::ST_LD_Y1;
            end
            lhhl_pkg::ST_LD_Y1:
            begin
                cmd.op     = lhhl_pkg::OP_LD_Y1;
                state_next = lhhl_pkg::ST_DECIDE;
            end
            lhhl_pkg::ST_DECIDE:
            begin
                cmd.op = lhhl_pkg::OP_DECIDE;
                if (status.sw_case)
                    state_next = status.grad ? lhhl_pkg::ST_FINISH : lhhl_pkg::ST_SW_GO;
                else if (status.zero_int)
                    state_next = lhhl_pkg::ST_FINISH;
                else
                    state_next = lhhl_pkg::ST_DIV_GO;
            end
            lhhl_pkg::ST_SW_GO:
            begin
                cmd.op     = lhhl_pkg::OP_SWITCH;
                cmd.go     = 1'b1;
                state_next = lhhl_pkg::ST_SW_WT;
            end
            lhhl_pkg::ST_SW_WT:
            begin
                cmd.op = lhhl_pkg::OP_SWITCH;
                if (status.done)
                    state_next = lhhl_pkg::ST_FINISH;
            end
            lhhl_pkg::ST_DIV_GO:
            begin
                cmd.op     = lhhl_pkg::OP_POS;
                cmd.go     = 1'b1;
                state_next = lhhl_pkg::ST_DIV_WT;
            end
            lhhl_pkg::ST_DIV_WT:
            begin
                cmd.op = lhhl_pkg::OP_POS;
                if (status.done)
                    state_next = lhhl_pkg::ST_C1_GO;
            end
            lhhl_pkg::ST_C1_GO:
            begin
                cmd.op     = lhhl_pkg::OP_C1;
                cmd.go     = 1'b1;
                state_next = lhhl_pkg::ST_C1_WT;
            end
            lhhl_pkg::ST_C1_WT:
            begin
                cmd.op = lhhl_pkg::OP_C1;
                if (status.done)
                    state_next = lhhl_pkg::ST_C1B_GO;
            end
            lhhl_pkg::ST_C1B_GO:
            begin
                cmd.op     = lhhl_pkg::OP_C1B;
                cmd.go     = 1'b1;
                state_next = lhhl_pkg::ST_C1B_WT;
            end
            lhhl_pkg::ST_C1B_WT:
            begin
                cmd.op = lhhl_pkg::OP_C1B;
                if (status.done)
                    state_next = lhhl_pkg::ST_C23;
            end
            lhhl_pkg::ST_C23:
            begin
                cmd.op     = lhhl_pkg::OP_C23;
                state_next = lhhl_pkg::ST_P1_GO;
            end
            lhhl_pkg::ST_P1_GO:
            begin
                cmd.op     = lhhl_pkg::OP_P1;
                cmd.go     = 1'b1;
                state_next = lhhl_pkg::ST_P1_WT;
            end
            lhhl_pkg::ST_P1_WT:
            begin
                cmd.op = lhhl_pkg::OP_P1;
                if (status.done)
                    state_next = lhhl_pkg::ST_P2_GO;
            end
            lhhl_pkg::ST_P2_GO:
            begin
                cmd.op     = lhhl_pkg::OP_P2;
                cmd.go     = 1'b1;
                state_next = lhhl_pkg::ST_P2_WT;
            end
            lhhl_pkg::ST_P2_WT:
            begin
                cmd.op = lhhl_pkg::OP_P2;
                if (status.done)
                    state_next = lhhl_pkg::ST_P3_GO;
            end
            lhhl_pkg::ST_P3_GO:
            begin
                cmd.op     = lhhl_pkg::OP_P3;
                cmd.go     = 1'b1;
                state_next = lhhl_pkg::ST_P3_WT;
            end
            lhhl_pkg::ST_P3_WT:
            begin
                cmd.op = lhhl_pkg::OP_P3;
                if (status.done)
                    state_next = lhhl_pkg::ST_FINISH;
            end
            lhhl_pkg::ST_FINISH:
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = lhhl_pkg::ST_IDLE;
                end
            default:
                state_next = lhhl_pkg::ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == lhhl_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
